>>> sv/aupk_pkg.sv
`timescale 1ns / 1ps

package aupk_pkg;

    // Number of 1 dB gain steps, from 0 dB down to -100 dB.
    localparam int GAIN_STEPS = 101;
    localparam int GAIN_IDX_W = $clog2(GAIN_STEPS);

    // Resolution codes (bytes per sample minus two).
    localparam logic [1:0] RES_16BIT   = 2'd0;
    localparam logic [1:0] RES_24BIT   = 2'd1;
    localparam logic [1:0] RES_32BIT   = 2'd2;
    localparam logic [1:0] RES_INVALID = 2'd3;

    // Output format codes; the unused code behaves as interleaved.
    localparam logic [1:0] MODE_INTERLEAVED = 2'd0;
    localparam logic [1:0] MODE_DUAL        = 2'd1;
    localparam logic [1:0] MODE_SPLIT       = 2'd2;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_RESOLUTION = 2'd0;
    localparam logic [1:0] REG_MODE       = 2'd1;
    localparam logic [1:0] REG_LEFT_VOL   = 2'd2;
    localparam logic [1:0] REG_RIGHT_VOL  = 2'd3;

    // Gain in 3.29 fixed point; 0x20000000 is unity.
    localparam logic [31:0] GAIN_TABLE [GAIN_STEPS] = '{
        32'h20000000, 32'h1c8520af, 32'h196b230b, 32'h16a77dea, 32'h1430cd74,
        32'h11feb33c, 32'h1009b9cf, 32'h0e4b3b63, 32'h0cbd4b3f, 32'h0b5aa19b,
        32'h0a1e89b1, 32'h0904d1bd, 32'h0809bcc3, 32'h0729f5d9, 32'h066284d5,
        32'h05b0c438, 32'h05125831, 32'h04852697, 32'h04074fcb, 32'h03972853,
        32'h03333333, 32'h02da1cde, 32'h028ab6b4, 32'h0243f2fd, 32'h0204e158,
        32'h01ccab86, 32'h019a9294, 32'h016dec56, 32'h0146211f, 32'h0122a9c2,
        32'h01030dc4, 32'h00e6e1c6, 32'h00cdc613, 32'h00b76562, 32'h00a373ae,
        32'h0091ad38, 32'h0081d59e, 32'h0073b70f, 32'h00672194, 32'h005bea6e,
        32'h0051eb85, 32'h004902e3, 32'h00411245, 32'h0039feb2, 32'h0033b022,
        32'h002e1127, 32'h00290ea8, 32'h002497a2, 32'h00209ce9, 32'h001d10f9,
        32'h0019e7c6, 32'h00171693, 32'h001493ce, 32'h001256f0, 32'h0010585e,
        32'h000e9152, 32'h000cfbc3, 32'h000b924e, 32'h000a5028, 32'h0009310b,
        32'h00083126, 32'h00074d16, 32'h000681d3, 32'h0005ccab, 32'h00052b36,
        32'h00049b50, 32'h00041b10, 32'h0003a8c3, 32'h000342e4, 32'h0002e818,
        32'h0002972d, 32'h00024f0e, 32'h00020ec7, 32'h0001d57e, 32'h0001a26f,
        32'h000174ee, 32'h00014c60, 32'h0001283b, 32'h00010804, 32'h0000eb4d,
        32'h0000d1b7, 32'h0000bae8, 32'h0000a695, 32'h00009477, 32'h00008452,
        32'h000075ee, 32'h0000691b, 32'h00005dad, 32'h0000537d, 32'h00004a68,
        32'h00004251, 32'h00003b1b, 32'h000034ad, 32'h00002ef3, 32'h000029d7,
        32'h0000254b, 32'h0000213c, 32'h00001d9f, 32'h00001a66, 32'h00001787,
        32'h000014f8
    };

    // One completed stereo frame with its gains.
    typedef struct packed {
        logic [31:0] left;
        logic [31:0] right;
        logic [31:0] left_gain;
        logic [31:0] right_gain;
    } frame_t;

    // Scaled samples of one frame.
    typedef struct packed {
        logic [31:0] left;
        logic [31:0] right;
    } scaled_t;

    // Attenuation index: clamp((-code) >> 8, 0, GAIN_STEPS - 1).
    function automatic logic [GAIN_IDX_W-1:0] gain_index(input logic [15:0] code);
        logic [16:0] neg;
        logic [7:0]  raw;
        neg = 17'd0 - {code[15], code};
        raw = 8'd0;
        if (!neg[16] && (neg != 17'd0))
        begin
            raw = neg[15:8];
        end
        if (raw > 8'(GAIN_STEPS - 1))
        begin
            raw = 8'(GAIN_STEPS - 1);
        end
        return GAIN_IDX_W'(raw);
    endfunction

    // Two's complement negation that saturates the most negative value.
    function automatic logic [31:0] negate_sat(input logic [31:0] x);
        if (x == 32'h80000000)
        begin
            return 32'h7fffffff;
        end
        return 32'd0 - x;
    endfunction

endpackage

>>> sv/audio_unpack_volume_format_core.sv
`timescale 1ns / 1ps

// Stereo PCM unpacker with per-channel dB volume. Little-endian packet bytes
// enter one word per clock, and the block takes a byte in every cycle unless
// a finished frame is held up by a stalled output. Left and right samples of
// 16, 24 or 32 bits are assembled left-justified, scaled by a gain from a
// 1 dB step table (32x32 multiply, shift right by 29), and sent as one or two
// result words per frame depending on the output mode. With nothing ahead of
// it, the first word of a frame passes from its last byte through the frame
// register, which loads with that byte, then the multiplier register and then
// the output register. The second word of a frame is presented in the cycle
// right after the first is taken. A partial frame at packet end is dropped.
// Configuration is written through a plain write port; the user must write it
// only while no frame is in flight, as the block itself does not enforce this.

module audio_unpack_volume_format_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_in,
    input  logic        packet_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] lane_a_word,
    output logic signed [31:0] lane_b_word,
    output logic        run_last
);
    import aupk_pkg::*;

    logic [1:0]  sample_resolution_reg;
    logic [1:0]  output_mode_reg;
    logic [15:0] left_volume_code_reg;
    logic [15:0] right_volume_code_reg;

    logic        frame_valid;
    frame_t      frame;
    logic        frame_ready;
    logic        scaled_valid;
    scaled_t     scaled;
    logic        scaled_ready;
    logic [31:0] lane_a;
    logic [31:0] lane_b;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_resolution_reg <= RES_16BIT;
            output_mode_reg       <= MODE_INTERLEAVED;
            left_volume_code_reg  <= 16'd0;
            right_volume_code_reg <= 16'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_RESOLUTION: sample_resolution_reg <= cfg_data[1:0];
                REG_MODE:       output_mode_reg       <= cfg_data[1:0];
                REG_LEFT_VOL:   left_volume_code_reg  <= cfg_data;
                REG_RIGHT_VOL:  right_volume_code_reg <= cfg_data;
                default:        output_mode_reg       <= output_mode_reg;
            endcase
        end
    end

    aupk_assembler u_assembler
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .sample_resolution (sample_resolution_reg),
        .left_volume_code  (left_volume_code_reg),
        .right_volume_code (right_volume_code_reg),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .byte_in           (byte_in),
        .packet_end        (packet_end),
        .frame_valid       (frame_valid),
        .frame             (frame),
        .frame_ready       (frame_ready)
    );

    aupk_scaler u_scaler
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame        (frame),
        .frame_ready  (frame_ready),
        .scaled_valid (scaled_valid),
        .scaled       (scaled),
        .scaled_ready (scaled_ready)
    );

    aupk_emitter u_emitter
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .output_mode  (output_mode_reg),
        .scaled_valid (scaled_valid),
        .scaled       (scaled),
        .scaled_ready (scaled_ready),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .lane_a_word  (lane_a),
        .lane_b_word  (lane_b),
        .run_last     (run_last)
    );

    assign lane_a_word = $signed(lane_a);
    assign lane_b_word = $signed(lane_b);

endmodule

>>> sv/aupk_assembler.sv
`timescale 1ns / 1ps

module aupk_assembler
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [1:0]            sample_resolution,
    input  logic [15:0]           left_volume_code,
    input  logic [15:0]           right_volume_code,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            byte_in,
    input  logic                  packet_end,
    output logic                  frame_valid,
    output aupk_pkg::frame_t      frame,
    input  logic                  frame_ready
);
    import aupk_pkg::*;

    logic [31:0] assembly_word_reg, assembly_word_next;
    logic [2:0]  byte_position_reg, byte_position_next;
    logic [31:0] held_left_sample_reg, held_left_sample_next;
    logic        frame_valid_reg, frame_valid_next;
    frame_t      frame_reg, frame_next;

    logic        accept;
    logic [2:0]  bps;
    logic [3:0]  frame_len;
    logic [2:0]  pos_eff;
    logic [2:0]  k;
    logic [1:0]  slot;
    logic [31:0] shifted;
    logic [31:0] word_new;
    logic        left_done;
    logic        frame_done;

    // A new word is refused only while a finished frame cannot move on.
    assign in_stall = frame_valid_reg && !frame_ready;
    assign accept   = in_valid && !in_stall;

    // Byte placement within the left-justified sample.
    always_comb
    begin
        bps       = {1'b0, sample_resolution} + 3'd2;
        frame_len = {bps, 1'b0};
        pos_eff   = ({1'b0, byte_position_reg} >= frame_len) ? 3'd0 : byte_position_reg;
        k         = (pos_eff < bps) ? pos_eff : (pos_eff - bps);
        slot      = 2'(3'd4 - bps + k);
        shifted   = {24'd0, byte_in} << {slot, 3'b000};
        word_new  = (k == 3'd0) ? shifted : (assembly_word_reg | shifted);
        left_done = (pos_eff == (bps - 3'd1));
        frame_done = ({1'b0, pos_eff} == (frame_len - 4'd1));
    end

    // Assembly state update.
    always_comb
    begin
        assembly_word_next    = assembly_word_reg;
        byte_position_next    = byte_position_reg;
        held_left_sample_next = held_left_sample_reg;
        if (accept)
        begin
            if (sample_resolution == RES_INVALID)
            begin
                assembly_word_next = 32'd0;
                byte_position_next = 3'd0;
            end
            else
            begin
                assembly_word_next = word_new;
                if (left_done)
                begin
                    held_left_sample_next = word_new;
                    byte_position_next    = pos_eff + 3'd1;
                end
                else if (frame_done)
                begin
                    byte_position_next = 3'd0;
                end
                else
                begin
                    byte_position_next = pos_eff + 3'd1;
                end
            end
            if (packet_end)
            begin
                assembly_word_next = 32'd0;
                byte_position_next = 3'd0;
            end
        end
    end

    // Frame register toward the scaler.
    always_comb
    begin
        frame_next       = frame_reg;
        frame_valid_next = frame_valid_reg;
        if (frame_ready)
        begin
            frame_valid_next = 1'b0;
        end
        if (accept && (sample_resolution != RES_INVALID) && frame_done)
        begin
            frame_valid_next     = 1'b1;
            frame_next.left      = held_left_sample_reg;
            frame_next.right     = word_new;
            frame_next.left_gain = GAIN_TABLE[gain_index(left_volume_code)];
            frame_next.right_gain = GAIN_TABLE[gain_index(right_volume_code)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            assembly_word_reg    <= 32'd0;
            byte_position_reg    <= 3'd0;
            held_left_sample_reg <= 32'd0;
            frame_valid_reg      <= 1'b0;
        end
        else
        begin
            assembly_word_reg    <= assembly_word_next;
            byte_position_reg    <= byte_position_next;
            held_left_sample_reg <= held_left_sample_next;
            frame_valid_reg      <= frame_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
    end

    assign frame_valid = frame_valid_reg;
    assign frame       = frame_reg;

endmodule

>>> sv/aupk_scaler.sv
`timescale 1ns / 1ps

module aupk_scaler
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  frame_valid,
    input  aupk_pkg::frame_t      frame,
    output logic                  frame_ready,
    output logic                  scaled_valid,
    output aupk_pkg::scaled_t     scaled,
    input  logic                  scaled_ready
);
    import aupk_pkg::*;

    logic        valid_reg;
    scaled_t     scaled_reg, scaled_next;
    logic signed [64:0] left_prod;
    logic signed [64:0] right_prod;

    assign frame_ready = !valid_reg || scaled_ready;

    // Signed sample times unsigned gain, then arithmetic shift right by 29.
    always_comb
    begin
        left_prod  = $signed(frame.left) * $signed({1'b0, frame.left_gain});
        right_prod = $signed(frame.right) * $signed({1'b0, frame.right_gain});
        scaled_next.left  = left_prod[60:29];
        scaled_next.right = right_prod[60:29];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (frame_ready)
        begin
            valid_reg <= frame_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_ready && frame_valid)
        begin
            scaled_reg <= scaled_next;
        end
    end

    assign scaled_valid = valid_reg;
    assign scaled       = scaled_reg;

endmodule

>>> sv/aupk_emitter.sv
`timescale 1ns / 1ps

module aupk_emitter
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [1:0]            output_mode,
    input  logic                  scaled_valid,
    input  aupk_pkg::scaled_t     scaled,
    output logic                  scaled_ready,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [31:0]           lane_a_word,
    output logic [31:0]           lane_b_word,
    output logic                  run_last
);
    import aupk_pkg::*;

    logic        out_valid_reg;
    logic [31:0] lane_a_reg, lane_b_reg;
    logic        run_last_reg;
    logic        pend_valid_reg;
    logic [31:0] pend_a_reg, pend_b_reg;

    logic        out_take;
    logic        can_load;
    logic        load;
    logic        is_dual;
    logic        is_split;
    logic [31:0] first_b;
    logic [31:0] second_a;
    logic [31:0] second_b;

    assign out_take = out_valid_reg && !out_stall;
    assign can_load = !pend_valid_reg && (!out_valid_reg || out_take);
    assign load     = scaled_valid && can_load;
    assign scaled_ready = can_load;

    // Lane formatting of the two words of a frame.
    always_comb
    begin
        is_dual  = (output_mode == MODE_DUAL);
        is_split = (output_mode == MODE_SPLIT);
        if (is_dual || is_split)
        begin
            first_b = scaled.right;
        end
        else
        begin
            first_b = 32'd0;
        end
        if (is_dual)
        begin
            second_a = negate_sat(scaled.left);
            second_b = negate_sat(scaled.right);
        end
        else
        begin
            second_a = scaled.right;
            second_b = 32'd0;
        end
    end

    // Output register with one pending word behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg  <= 1'b1;
            pend_valid_reg <= !is_split;
        end
        else if (out_take)
        begin
            out_valid_reg  <= pend_valid_reg;
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            lane_a_reg   <= scaled.left;
            lane_b_reg   <= first_b;
            run_last_reg <= is_split;
            pend_a_reg   <= second_a;
            pend_b_reg   <= second_b;
        end
        else if (out_take && pend_valid_reg)
        begin
            lane_a_reg   <= pend_a_reg;
            lane_b_reg   <= pend_b_reg;
            run_last_reg <= 1'b1;
        end
    end

    assign out_valid   = out_valid_reg;
    assign lane_a_word = lane_a_reg;
    assign lane_b_word = lane_b_reg;
    assign run_last    = run_last_reg;

endmodule

>>> bench/aupk_lane_checker.sv
`timescale 1ns / 1ps

module aupk_lane_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [7:0]         byte_in,
    input  logic               packet_end,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] lane_a_word,
    input  logic signed [31:0] lane_b_word,
    input  logic               run_last,
    input  logic               run_done,
    output int                 mismatches,
    output int                 words_waiting,
    output int                 words_seen
);
    import aupk_pkg::*;

    localparam int ATTEN_STEPS = 101;
    localparam int MAX_PRINTED = 40;

    // Gain per 1 dB of attenuation, 3.29 fixed point.
    localparam logic [31:0] ATTEN_GAIN [ATTEN_STEPS] = '{
        32'h20000000, 32'h1c8520af, 32'h196b230b, 32'h16a77dea, 32'h1430cd74,
        32'h11feb33c, 32'h1009b9cf, 32'h0e4b3b63, 32'h0cbd4b3f, 32'h0b5aa19b,
        32'h0a1e89b1, 32'h0904d1bd, 32'h0809bcc3, 32'h0729f5d9, 32'h066284d5,
        32'h05b0c438, 32'h05125831, 32'h04852697, 32'h04074fcb, 32'h03972853,
        32'h03333333, 32'h02da1cde, 32'h028ab6b4, 32'h0243f2fd, 32'h0204e158,
        32'h01ccab86, 32'h019a9294, 32'h016dec56, 32'h0146211f, 32'h0122a9c2,
        32'h01030dc4, 32'h00e6e1c6, 32'h00cdc613, 32'h00b76562, 32'h00a373ae,
        32'h0091ad38, 32'h0081d59e, 32'h0073b70f, 32'h00672194, 32'h005bea6e,
        32'h0051eb85, 32'h004902e3, 32'h00411245, 32'h0039feb2, 32'h0033b022,
        32'h002e1127, 32'h00290ea8, 32'h002497a2, 32'h00209ce9, 32'h001d10f9,
        32'h0019e7c6, 32'h00171693, 32'h001493ce, 32'h001256f0, 32'h0010585e,
        32'h000e9152, 32'h000cfbc3, 32'h000b924e, 32'h000a5028, 32'h0009310b,
        32'h00083126, 32'h00074d16, 32'h000681d3, 32'h0005ccab, 32'h00052b36,
        32'h00049b50, 32'h00041b10, 32'h0003a8c3, 32'h000342e4, 32'h0002e818,
        32'h0002972d, 32'h00024f0e, 32'h00020ec7, 32'h0001d57e, 32'h0001a26f,
        32'h000174ee, 32'h00014c60, 32'h0001283b, 32'h00010804, 32'h0000eb4d,
        32'h0000d1b7, 32'h0000bae8, 32'h0000a695, 32'h00009477, 32'h00008452,
        32'h000075ee, 32'h0000691b, 32'h00005dad, 32'h0000537d, 32'h00004a68,
        32'h00004251, 32'h00003b1b, 32'h000034ad, 32'h00002ef3, 32'h000029d7,
        32'h0000254b, 32'h0000213c, 32'h00001d9f, 32'h00001a66, 32'h00001787,
        32'h000014f8
    };

    typedef struct {
        logic [31:0] lane_a;
        logic [31:0] lane_b;
        logic        last;
    } lane_word_t;

    // Shadow of the configuration registers.
    logic [1:0]  res_code;
    logic [1:0]  lane_mode;
    logic [15:0] vol_left;
    logic [15:0] vol_right;

    // Unpacking state of the predicted block.
    logic [31:0] asm_word;
    logic [31:0] held_left;
    int unsigned byte_pos;

    lane_word_t  expected_lane_words [$];
    lane_word_t  oldest;
    bit          leftovers_reported;

    // Attenuation index is the negated code in whole dB, clamped to the table.
    function automatic logic [31:0] volume_gain(input logic [15:0] code);
        int atten;
        int idx;
        atten = -int'($signed(code));
        idx = (atten > 0) ? (atten >> 8) : 0;
        if (idx > ATTEN_STEPS - 1)
        begin
            idx = ATTEN_STEPS - 1;
        end
        return ATTEN_GAIN[idx];
    endfunction

    // Signed sample times unsigned gain, arithmetic shift right by 29.
    function automatic logic [31:0] apply_gain(input logic [31:0] sample,
                                               input logic [31:0] gain);
        longint product;
        product = longint'($signed(sample)) * longint'(gain);
        return product[60:29];
    endfunction

    function automatic logic [31:0] negate_clamped(input logic [31:0] x);
        if (x == 32'h80000000)
        begin
            return 32'h7fffffff;
        end
        return 32'd0 - x;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < MAX_PRINTED)
        begin
            $display("ERROR at %0t ns: %s: got %08h, expected %08h", $time, what, got, want);
        end
        mismatches++;
    endtask

    // Feed one byte through the unpacker and queue the words it produces.
    task automatic unpack_byte(input logic [7:0] b, input logic end_flag);
        int unsigned bps;
        int unsigned k;
        int unsigned shift;
        logic [31:0] left_out;
        logic [31:0] right_out;
        if (res_code == RES_INVALID)
        begin
            byte_pos = 0;
            asm_word = 32'd0;
            return;
        end
        bps = res_code + 2;
        // A resolution change can leave the position past the new frame length.
        if (byte_pos >= 2 * bps)
        begin
            byte_pos = 0;
        end
        k = (byte_pos < bps) ? byte_pos : byte_pos - bps;
        shift = 32 - 8 * bps + 8 * k;
        if (k == 0)
        begin
            asm_word = {24'd0, b} << shift;
        end
        else
        begin
            asm_word = asm_word | ({24'd0, b} << shift);
        end

        if (byte_pos == bps - 1)
        begin
            held_left = asm_word;
            byte_pos++;
        end
        else if (byte_pos == 2 * bps - 1)
        begin
            left_out = apply_gain(held_left, volume_gain(vol_left));
            right_out = apply_gain(asm_word, volume_gain(vol_right));
            case (lane_mode)
                MODE_DUAL:
                begin
                    expected_lane_words.push_back(lane_word_t'{left_out, right_out, 1'b0});
                    expected_lane_words.push_back(lane_word_t'{negate_clamped(left_out),
                                                               negate_clamped(right_out),
                                                               1'b1});
                end
                MODE_SPLIT:
                begin
                    expected_lane_words.push_back(lane_word_t'{left_out, right_out, 1'b1});
                end
                default:
                begin
                    expected_lane_words.push_back(lane_word_t'{left_out, 32'd0, 1'b0});
                    expected_lane_words.push_back(lane_word_t'{right_out, 32'd0, 1'b1});
                end
            endcase
            byte_pos = 0;
        end
        else
        begin
            byte_pos++;
        end

        // Packet end drops whatever partial frame is left.
        if (end_flag)
        begin
            byte_pos = 0;
            asm_word = 32'd0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_code = RES_16BIT;
            lane_mode = MODE_INTERLEAVED;
            vol_left = 16'd0;
            vol_right = 16'd0;
            asm_word = 32'd0;
            held_left = 32'd0;
            byte_pos = 0;
            expected_lane_words.delete();
            leftovers_reported = 1'b0;
            mismatches = 0;
            words_waiting = 0;
            words_seen = 0;
        end
        else
        begin
            // Track register writes.
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_RESOLUTION: res_code = cfg_data[1:0];
                    REG_MODE:       lane_mode = cfg_data[1:0];
                    REG_LEFT_VOL:   vol_left = cfg_data;
                    REG_RIGHT_VOL:  vol_right = cfg_data;
                    default:        ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                unpack_byte(byte_in, packet_end);
            end

            // Compare each accepted result word with the oldest prediction.
            if (out_valid && !out_stall)
            begin
                words_seen++;
                if (expected_lane_words.size() == 0)
                begin
                    report_mismatch("result word with none expected", lane_a_word, 32'd0);
                end
                else
                begin
                    oldest = expected_lane_words.pop_front();
                    if (lane_a_word !== oldest.lane_a)
                    begin
                        report_mismatch("lane_a_word", lane_a_word, oldest.lane_a);
                    end
                    if (lane_b_word !== oldest.lane_b)
                    begin
                        report_mismatch("lane_b_word", lane_b_word, oldest.lane_b);
                    end
                    if (run_last !== oldest.last)
                    begin
                        report_mismatch("run_last", {31'd0, run_last}, {31'd0, oldest.last});
                    end
                end
            end

            // At the end of the run, every prediction still queued is a miss.
            if (run_done && !leftovers_reported)
            begin
                leftovers_reported = 1'b1;
                while (expected_lane_words.size() != 0)
                begin
                    oldest = expected_lane_words.pop_front();
                    report_mismatch("result word never arrived", 32'd0, oldest.lane_a);
                end
            end

            words_waiting = expected_lane_words.size();
        end
    end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import aupk_pkg::*;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 10;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int SEGMENT_WORDS   = 70;

    // Idle percentages per phase: none, sender idle, receiver stalling, both.
    localparam int unsigned SEND_IDLE [4] = '{0, 76, 0, 15};
    localparam int unsigned RECV_IDLE [4] = '{0, 0, 76, 15};

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write = 1'b0;
    logic [1:0]         cfg_index = 2'd0;
    logic [15:0]        cfg_data = 16'd0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         byte_in = 8'd0;
    logic               packet_end = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] lane_a_word;
    logic signed [31:0] lane_b_word;
    logic               run_last;
    logic               run_done = 1'b0;

    int mismatches;
    int words_waiting;
    int words_seen;

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_served = 0;
    int unsigned hold_count = 0;
    int unsigned words_sent = 0;
    logic [1:0]  cur_res = RES_16BIT;

    audio_unpack_volume_format_core u_dut (.*);

    aupk_lane_checker u_checker (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Output stall: a requested hold-off first, otherwise random stalls.
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_count <= HOLD_OFF_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else if (hold_count > 0)
        begin
            hold_count <= hold_count - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    // Offer one word and wait until the block takes it.
    task automatic send_byte(input logic [7:0] b, input logic last_byte);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        byte_in <= b;
        packet_end <= last_byte;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        words_sent++;
    endtask

    // Write all four registers back to back.
    task automatic configure(input logic [1:0] res, input logic [1:0] mode,
                             input logic [15:0] left_vol, input logic [15:0] right_vol);
        cfg_write <= 1'b1;
        cfg_index <= REG_RESOLUTION;
        cfg_data <= {14'd0, res};
        @(posedge clk);
        cfg_index <= REG_MODE;
        cfg_data <= {14'd0, mode};
        @(posedge clk);
        cfg_index <= REG_LEFT_VOL;
        cfg_data <= left_vol;
        @(posedge clk);
        cfg_index <= REG_RIGHT_VOL;
        cfg_data <= right_vol;
        @(posedge clk);
        cfg_write <= 1'b0;
        cur_res = res;
    endtask

    // Wait with the input idle until every predicted word has come out.
    task automatic wait_drained();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_waiting != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hff;
            2:       return 8'h80;
            3:       return 8'h7f;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [15:0] pick_volume();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'h9c00;
            4:       return 16'h9b00;
            5:       return 16'(-$urandom_range(25856));
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    // Mostly whole packets of random samples; some cut short or left open.
    task automatic send_packets(input int unsigned n_words);
        int unsigned sent;
        int unsigned bps;
        int unsigned len;
        bit          open_packet;
        sent = 0;
        bps = cur_res + 2;
        while (sent < n_words)
        begin
            len = $urandom_range(1, 4) * 2 * bps;
            if ($urandom_range(9) == 0)
            begin
                len = $urandom_range(1, len);
            end
            open_packet = ($urandom_range(9) == 0);
            for (int unsigned i = 0; i < len; i++)
            begin
                send_byte(pick_byte(), (i == len - 1) && !open_packet);
            end
            sent += len;
            // Now and then the sender pauses until the output has caught up.
            if ($urandom_range(11) == 0)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (words_waiting != 0)
                begin
                    @(posedge clk);
                end
            end
        end
        in_valid <= 1'b0;
    endtask

    task automatic random_segment(input int unsigned n_words);
        configure(2'($urandom_range(2)), 2'($urandom_range(3)), pick_volume(), pick_volume());
        send_packets(n_words);
        wait_drained();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: 16-bit, interleaved, 0 dB on both channels.
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h7f, 1'b1);
        wait_drained();

        // Dual lanes with a full-scale negative left sample: the inverted copy saturates.
        configure(RES_16BIT, MODE_DUAL, 16'h0000, 16'h0000);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b1);
        wait_drained();

        // 24-bit split lanes at the extreme volume codes.
        configure(RES_24BIT, MODE_SPLIT, 16'h8000, 16'h7fff);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b1);
        wait_drained();

        // 32-bit with the unused mode code: a packet ending mid-frame, then an
        // open partial frame left behind.
        configure(RES_32BIT, 2'd3, 16'h9c00, 16'hfed4);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b1);
        for (int i = 0; i < 5; i++)
        begin
            send_byte(pick_byte(), 1'b0);
        end
        wait_drained();

        // Back to 16-bit: the stale position restarts the frame.
        configure(RES_16BIT, MODE_INTERLEAVED, 16'hff01, 16'h9b00);
        send_byte(8'h34, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'hcd, 1'b0);
        send_byte(8'hab, 1'b1);
        wait_drained();

        // The invalid resolution code ignores bytes.
        configure(RES_INVALID, MODE_SPLIT, 16'h0000, 16'h0000);
        send_byte(8'h5a, 1'b0);
        send_byte(8'ha5, 1'b1);
        wait_drained();

        // Random packets under each idling pattern.
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = SEND_IDLE[p];
            stall_pct = RECV_IDLE[p];
            random_segment(SEGMENT_WORDS);
            random_segment(SEGMENT_WORDS);
        end

        // Long output hold-off while the sender keeps going, filling the block.
        send_idle_pct = 0;
        stall_pct = 0;
        configure(RES_16BIT, MODE_DUAL, pick_volume(), pick_volume());
        hold_requests++;
        send_packets(80);
        wait_drained();

        run_done <= 1'b1;
        repeat (3) @(posedge clk);

        $display("Run covered %0d input words and %0d result words over 16/24/32-bit samples,",
                 words_sent, words_seen);
        $display("all output modes, volume extremes, partial frames and a %0d-cycle hold-off.",
                 HOLD_OFF_CYCLES);
        if (mismatches == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/aupk_pkg.sv
sv/aupk_assembler.sv
sv/aupk_scaler.sv
sv/aupk_emitter.sv
sv/audio_unpack_volume_format_core.sv
bench/aupk_lane_checker.sv
bench/tb_top.sv
